>>> hdl/jkef_pkg.sv
// Shared types and constants for the joystick key event filter.
// No dependencies; every other file of the block refers to this package.
package jkef_pkg;

    // Widths of the fields and registers
    localparam int unsigned PORT_W       = 8;
    localparam int unsigned KEY_CODE_W   = 4;
    localparam int unsigned TICK_W       = 16;
    localparam int unsigned CFG_IDX_W    = 2;
    localparam int unsigned SIDE_KEY_CNT = 4;

    // Request types
    localparam logic REQ_SNAPSHOT = 1'b0;
    localparam logic REQ_TICK     = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENTER_DELAY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_DELAY = 2'd1;

    // Configuration reset values
    localparam logic [TICK_W-1:0] ENTER_DELAY_RST   = 16'd200;
    localparam logic [TICK_W-1:0] RELEASE_DELAY_RST = 16'd80;
    localparam logic [TICK_W-1:0] TICK_MAX          = 16'hFFFF;

    // Joystick port bit positions
    localparam int unsigned JOY_BIT_BUTTON = 0;
    localparam int unsigned JOY_BIT_DOWN   = 1;
    localparam int unsigned JOY_BIT_LEFT   = 2;
    localparam int unsigned JOY_BIT_UP     = 3;
    localparam int unsigned JOY_BIT_RIGHT  = 4;

    // Joystick key identifiers: none, else key code plus one
    typedef logic [2:0] t_key_id;
    localparam t_key_id KEY_ID_NONE  = 3'd0;
    localparam t_key_id KEY_ID_UP    = 3'd1;
    localparam t_key_id KEY_ID_DOWN  = 3'd2;
    localparam t_key_id KEY_ID_LEFT  = 3'd3;
    localparam t_key_id KEY_ID_RIGHT = 3'd4;
    localparam t_key_id KEY_ID_ENTER = 3'd5;

    // First side key code (top left); the others follow in port bit order
    localparam logic [KEY_CODE_W-1:0] KEY_CODE_SIDE_BASE = 4'd5;

    // All events caused by one input item
    typedef struct packed {
        logic                    joy_vld;
        logic [KEY_CODE_W-1:0]   joy_code;
        logic                    joy_pressed;
        logic [SIDE_KEY_CNT-1:0] side_mask;
        logic [SIDE_KEY_CNT-1:0] side_pressed;
    } t_evt_bundle;

endpackage

>>> hdl/jkef_if.sv
// Handshake channel interfaces: input items, result events, register writes.
// Depends on jkef_pkg for field widths.
interface jkef_in_if;
    logic                            valid;
    logic                            ready;
    logic                            req_type;
    logic [jkef_pkg::PORT_W-1:0]     joystick_port;
    logic [jkef_pkg::PORT_W-1:0]     key_port;

    modport source (output valid, req_type, joystick_port, key_port, input ready);
    modport sink   (input valid, req_type, joystick_port, key_port, output ready);
endinterface

interface jkef_evt_if;
    logic                            valid;
    logic                            ready;
    logic [jkef_pkg::KEY_CODE_W-1:0] key_code;
    logic                            pressed;
    logic                            last_event;

    modport source (output valid, key_code, pressed, last_event, input ready);
    modport sink   (input valid, key_code, pressed, last_event, output ready);
endinterface

interface jkef_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [jkef_pkg::CFG_IDX_W-1:0]  index;
    logic [jkef_pkg::TICK_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/joystick_key_event_filter.sv
// Joystick key event filter: an item is classified combinationally and its
// event bundle, if any, is queued at the transfer; the back end moves the
// events into the output register. Throughput: one item per cycle while
// the bundle queue has room, and one event per cycle while o_evt.ready is high.
// Reset (synchronous, active low) clears key state, timers, queue and output,
// and loads enter delay 200 and release delay 80. Depends on jkef_pkg, jkef_if.
module joystick_key_event_filter #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    jkef_in_if.sink     i_in,
    jkef_cfg_if.sink    i_cfg,
    jkef_evt_if.source  o_evt
);

    logic                  push;
    logic                  pop;
    logic                  q_full;
    logic                  q_valid;
    jkef_pkg::t_evt_bundle push_bundle;
    jkef_pkg::t_evt_bundle head_bundle;

    // Classify items and keep the key state
    jkef_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_q_full (q_full),
        .o_push   (push),
        .o_bundle (push_bundle)
    );

    // Bundle queue between front and back
    jkef_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (push_bundle),
        .i_pop    (pop),
        .o_full   (q_full),
        .o_valid  (q_valid),
        .o_bundle (head_bundle)
    );

    // Serialize events to the output
    jkef_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_bundle  (head_bundle),
        .o_pop     (pop),
        .o_evt     (o_evt)
    );

endmodule

>>> hdl/jkef_front.sv
// Front end: takes snapshots and ticks, keeps the key state and timers,
// and pushes one event bundle per item that causes events. Uses jkef_pkg.
module jkef_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    jkef_in_if.sink               i_in,
    jkef_cfg_if.sink              i_cfg,
    input  logic                  i_q_full,
    output logic                  o_push,
    output jkef_pkg::t_evt_bundle o_bundle
);

    logic [jkef_pkg::TICK_W-1:0]     r_enter_delay;
    logic [jkef_pkg::TICK_W-1:0]     r_release_delay;
    logic [2*jkef_pkg::PORT_W-1:0]   r_prev, n_prev;
    jkef_pkg::t_key_id               r_active, n_active;
    jkef_pkg::t_key_id               r_queued, n_queued;
    logic                            r_pending, n_pending;
    logic [jkef_pkg::TICK_W-1:0]     r_count, n_count;
    logic [jkef_pkg::TICK_W-1:0]     r_tsv, n_tsv;

    logic [jkef_pkg::PORT_W-1:0]     jch;
    logic [jkef_pkg::PORT_W-1:0]     kch;
    jkef_pkg::t_key_id               sel_key;
    logic                            sel_vld;
    logic                            sel_press;
    logic                            accept;
    jkef_pkg::t_evt_bundle           bundle;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !i_q_full;
    assign accept      = i_in.valid && !i_q_full;

    // Edge detect against the previous snapshot
    assign jch = i_in.joystick_port ^ r_prev[2*jkef_pkg::PORT_W-1:jkef_pkg::PORT_W];
    assign kch = i_in.key_port ^ r_prev[jkef_pkg::PORT_W-1:0];

    // Highest-priority changed joystick line; button gated by enter delay
    always_comb begin
        sel_key   = jkef_pkg::KEY_ID_NONE;
        sel_vld   = 1'b0;
        sel_press = 1'b0;
        if (jch[jkef_pkg::JOY_BIT_UP]) begin
            sel_key   = jkef_pkg::KEY_ID_UP;
            sel_vld   = 1'b1;
            sel_press = i_in.joystick_port[jkef_pkg::JOY_BIT_UP];
        end else if (jch[jkef_pkg::JOY_BIT_DOWN]) begin
            sel_key   = jkef_pkg::KEY_ID_DOWN;
            sel_vld   = 1'b1;
            sel_press = i_in.joystick_port[jkef_pkg::JOY_BIT_DOWN];
        end else if (jch[jkef_pkg::JOY_BIT_LEFT]) begin
            sel_key   = jkef_pkg::KEY_ID_LEFT;
            sel_vld   = 1'b1;
            sel_press = i_in.joystick_port[jkef_pkg::JOY_BIT_LEFT];
        end else if (jch[jkef_pkg::JOY_BIT_RIGHT]) begin
            sel_key   = jkef_pkg::KEY_ID_RIGHT;
            sel_vld   = 1'b1;
            sel_press = i_in.joystick_port[jkef_pkg::JOY_BIT_RIGHT];
        end else if (jch[jkef_pkg::JOY_BIT_BUTTON]) begin
            sel_key   = jkef_pkg::KEY_ID_ENTER;
            sel_vld   = (r_active == jkef_pkg::KEY_ID_ENTER) || (r_tsv > r_enter_delay);
            sel_press = i_in.joystick_port[jkef_pkg::JOY_BIT_BUTTON];
        end
    end

    // Next state and event bundle for the item on the input
    always_comb begin
        n_prev    = r_prev;
        n_active  = r_active;
        n_queued  = r_queued;
        n_pending = r_pending;
        n_count   = r_count;
        n_tsv     = r_tsv;
        bundle    = '0;
        if (i_in.req_type == jkef_pkg::REQ_TICK) begin
            if (r_tsv != jkef_pkg::TICK_MAX) begin
                n_tsv = r_tsv + 1'b1;
            end
            if (r_pending) begin
                if (r_count <= jkef_pkg::TICK_W'(1)) begin
                    n_count   = '0;
                    n_pending = 1'b0;
                    if (r_queued != jkef_pkg::KEY_ID_NONE) begin
                        bundle.joy_vld     = 1'b1;
                        bundle.joy_code    = jkef_pkg::KEY_CODE_W'(r_queued - 1'b1);
                        bundle.joy_pressed = 1'b0;
                        n_queued = jkef_pkg::KEY_ID_NONE;
                        n_active = jkef_pkg::KEY_ID_NONE;
                        n_tsv    = '0;
                    end
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
        end else begin
            if (sel_vld) begin
                if (sel_press) begin
                    if (r_active == jkef_pkg::KEY_ID_NONE) begin
                        bundle.joy_vld     = 1'b1;
                        bundle.joy_code    = jkef_pkg::KEY_CODE_W'(sel_key - 1'b1);
                        bundle.joy_pressed = 1'b1;
                        n_active = sel_key;
                        n_tsv    = '0;
                    end else if (r_active == sel_key && r_queued == sel_key) begin
                        n_queued = jkef_pkg::KEY_ID_NONE;
                    end
                end else if (r_active == sel_key && r_queued == jkef_pkg::KEY_ID_NONE) begin
                    n_queued = sel_key;
                    if (!r_pending) begin
                        n_pending = 1'b1;
                        n_count   = r_release_delay;
                    end
                end
            end
            // Side keys reported directly
            bundle.side_mask    = kch[jkef_pkg::SIDE_KEY_CNT-1:0];
            bundle.side_pressed = i_in.key_port[jkef_pkg::SIDE_KEY_CNT-1:0];
            n_prev = {i_in.joystick_port, i_in.key_port};
        end
    end

    assign o_bundle = bundle;
    assign o_push   = accept && (bundle.joy_vld || (|bundle.side_mask));

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enter_delay   <= jkef_pkg::ENTER_DELAY_RST;
            r_release_delay <= jkef_pkg::RELEASE_DELAY_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                jkef_pkg::CFG_ENTER_DELAY:   r_enter_delay   <= i_cfg.data;
                jkef_pkg::CFG_RELEASE_DELAY: r_release_delay <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Key and timer state, updated on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev    <= '0;
            r_active  <= jkef_pkg::KEY_ID_NONE;
            r_queued  <= jkef_pkg::KEY_ID_NONE;
            r_pending <= 1'b0;
            r_count   <= '0;
            r_tsv     <= '0;
        end else if (accept) begin
            r_prev    <= n_prev;
            r_active  <= n_active;
            r_queued  <= n_queued;
            r_pending <= n_pending;
            r_count   <= n_count;
            r_tsv     <= n_tsv;
        end
    end

endmodule

>>> hdl/jkef_queue.sv
// Short FIFO of event bundles between the front and back ends.
// Uses jkef_pkg for the bundle type.
module jkef_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  jkef_pkg::t_evt_bundle i_bundle,
    input  logic                  i_pop,
    output logic                  o_full,
    output logic                  o_valid,
    output jkef_pkg::t_evt_bundle o_bundle
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    jkef_pkg::t_evt_bundle r_mem [DEPTH];
    logic [PTR_W-1:0]      r_wr_ptr;
    logic [PTR_W-1:0]      r_rd_ptr;
    logic [CNT_W-1:0]      r_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_full   = (r_count == CNT_W'(DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_bundle = r_mem[r_rd_ptr];
    assign do_push  = i_push && !o_full;
    assign do_pop   = i_pop && o_valid;

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_bundle;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> hdl/jkef_back.sv
// Back end: walks the queue head bundle one event per cycle, unless the output
// stalls, into a registered output stage; marks the last event. Uses jkef_pkg.
module jkef_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  jkef_pkg::t_evt_bundle i_bundle,
    output logic                  o_pop,
    jkef_evt_if.source            o_evt
);

    logic                                r_joy_done;
    logic [jkef_pkg::SIDE_KEY_CNT-1:0]   r_side_done;
    logic                                r_out_vld;
    logic [jkef_pkg::KEY_CODE_W-1:0]     r_out_code;
    logic                                r_out_pressed;
    logic                                r_out_last;

    logic                                joy_left;
    logic [jkef_pkg::SIDE_KEY_CNT-1:0]   side_left;
    logic [jkef_pkg::SIDE_KEY_CNT-1:0]   side_pick;
    logic [jkef_pkg::KEY_CODE_W-1:0]     sel_code;
    logic                                sel_pressed;
    logic                                sel_last;
    logic                                load;

    assign joy_left  = i_bundle.joy_vld && !r_joy_done;
    assign side_left = i_bundle.side_mask & ~r_side_done;

    // Pick the next event: joystick first, then side keys in bit order
    always_comb begin
        side_pick   = '0;
        sel_code    = i_bundle.joy_code;
        sel_pressed = i_bundle.joy_pressed;
        for (int i = jkef_pkg::SIDE_KEY_CNT - 1; i >= 0; i--) begin
            if (side_left[i]) begin
                side_pick = jkef_pkg::SIDE_KEY_CNT'(1) << i;
            end
        end
        if (joy_left) begin
            sel_last = !(|side_left);
        end else begin
            sel_last = !(|(side_left & ~side_pick));
            for (int i = 0; i < jkef_pkg::SIDE_KEY_CNT; i++) begin
                if (side_pick[i]) begin
                    sel_code    = jkef_pkg::KEY_CODE_SIDE_BASE + jkef_pkg::KEY_CODE_W'(i);
                    sel_pressed = i_bundle.side_pressed[i];
                end
            end
        end
    end

    assign load  = i_q_valid && (!r_out_vld || o_evt.ready);
    assign o_pop = load && sel_last;

    // Progress through the head bundle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_joy_done  <= 1'b0;
            r_side_done <= '0;
        end else if (load) begin
            if (sel_last) begin
                r_joy_done  <= 1'b0;
                r_side_done <= '0;
            end else if (joy_left) begin
                r_joy_done  <= 1'b1;
            end else begin
                r_side_done <= r_side_done | side_pick;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (load) begin
            r_out_vld <= 1'b1;
        end else if (o_evt.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_code    <= sel_code;
            r_out_pressed <= sel_pressed;
            r_out_last    <= sel_last;
        end
    end

    assign o_evt.valid      = r_out_vld;
    assign o_evt.key_code   = r_out_code;
    assign o_evt.pressed    = r_out_pressed;
    assign o_evt.last_event = r_out_last;

endmodule

>>> dv/jkef_event_checker.sv
// Checker for the joystick key event filter: watches the item, register and
// event channels, predicts the key events and compares them in order.
// Depends on jkef_pkg and the channel interfaces in jkef_if.sv.
module jkef_event_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    jkef_in_if          i_in,
    jkef_cfg_if         i_cfg,
    jkef_evt_if         i_evt,
    output int unsigned o_pending,
    output int unsigned o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [jkef_pkg::KEY_CODE_W-1:0] key_code;
        logic                            pressed;
        logic                            last_event;
    } t_key_event;

    // Register copies
    logic [jkef_pkg::TICK_W-1:0] enter_delay;
    logic [jkef_pkg::TICK_W-1:0] release_delay;

    // Key state of the filter
    logic [jkef_pkg::PORT_W-1:0] prev_joy;
    logic [jkef_pkg::PORT_W-1:0] prev_keys;
    jkef_pkg::t_key_id           active_key;
    jkef_pkg::t_key_id           queued_key;
    logic                        timer_running;
    logic [jkef_pkg::TICK_W-1:0] timer_left;
    logic [jkef_pkg::TICK_W-1:0] idle_ticks;

    t_key_event        item_events[$];
    t_key_event        expected_events[$];
    int unsigned       fail_total;

    assign o_fail_count = fail_total;

    function automatic void add_event(input logic [jkef_pkg::KEY_CODE_W-1:0] code,
                                      input logic down);
        item_events.push_back('{key_code: code, pressed: down, last_event: 1'b0});
    endfunction

    // One changed joystick line; only one joystick key may be active
    function automatic void joy_line(input logic down, input jkef_pkg::t_key_id key);
        if (down) begin
            if (active_key == jkef_pkg::KEY_ID_NONE) begin
                add_event(jkef_pkg::KEY_CODE_W'(key) - 1'b1, 1'b1);
                active_key = key;
                idle_ticks = '0;
            end else if (active_key == key && queued_key == key) begin
                queued_key = jkef_pkg::KEY_ID_NONE;   // bounce cancels the held release
            end
        end else if (active_key == key && queued_key == jkef_pkg::KEY_ID_NONE) begin
            queued_key = key;
            // a running timer is left as it is
            if (!timer_running) begin
                timer_running = 1'b1;
                timer_left = release_delay;
            end
        end
    endfunction

    function automatic void predict_tick();
        if (idle_ticks != jkef_pkg::TICK_MAX) idle_ticks++;
        if (timer_running) begin
            if (timer_left <= 1) begin
                timer_left = '0;
                timer_running = 1'b0;
                if (queued_key != jkef_pkg::KEY_ID_NONE) begin
                    add_event(jkef_pkg::KEY_CODE_W'(queued_key) - 1'b1, 1'b0);
                    queued_key = jkef_pkg::KEY_ID_NONE;
                    active_key = jkef_pkg::KEY_ID_NONE;
                    idle_ticks = '0;
                end
            end else begin
                timer_left--;
            end
        end
    endfunction

    function automatic void predict_snapshot(input logic [jkef_pkg::PORT_W-1:0] joy,
                                             input logic [jkef_pkg::PORT_W-1:0] keys);
        logic [jkef_pkg::PORT_W-1:0] joy_chg;
        logic [jkef_pkg::PORT_W-1:0] key_chg;
        joy_chg = joy ^ prev_joy;
        key_chg = keys ^ prev_keys;
        // highest-priority changed line only: up, down, left, right, button
        if (joy_chg[jkef_pkg::JOY_BIT_UP])
            joy_line(joy[jkef_pkg::JOY_BIT_UP], jkef_pkg::KEY_ID_UP);
        else if (joy_chg[jkef_pkg::JOY_BIT_DOWN])
            joy_line(joy[jkef_pkg::JOY_BIT_DOWN], jkef_pkg::KEY_ID_DOWN);
        else if (joy_chg[jkef_pkg::JOY_BIT_LEFT])
            joy_line(joy[jkef_pkg::JOY_BIT_LEFT], jkef_pkg::KEY_ID_LEFT);
        else if (joy_chg[jkef_pkg::JOY_BIT_RIGHT])
            joy_line(joy[jkef_pkg::JOY_BIT_RIGHT], jkef_pkg::KEY_ID_RIGHT);
        else if (joy_chg[jkef_pkg::JOY_BIT_BUTTON] &&
                 (active_key == jkef_pkg::KEY_ID_ENTER || idle_ticks > enter_delay))
            joy_line(joy[jkef_pkg::JOY_BIT_BUTTON], jkef_pkg::KEY_ID_ENTER);
        // side keys go straight through
        for (int i = 0; i < jkef_pkg::SIDE_KEY_CNT; i++) begin
            if (key_chg[i])
                add_event(jkef_pkg::KEY_CODE_SIDE_BASE + jkef_pkg::KEY_CODE_W'(i), keys[i]);
        end
        prev_joy = joy;
        prev_keys = keys;
    endfunction

    function automatic void predict_item(input logic kind,
                                         input logic [jkef_pkg::PORT_W-1:0] joy,
                                         input logic [jkef_pkg::PORT_W-1:0] keys);
        item_events.delete();
        if (kind == jkef_pkg::REQ_TICK) predict_tick();
        else predict_snapshot(joy, keys);
        if (item_events.size() > 0) item_events[item_events.size() - 1].last_event = 1'b1;
        foreach (item_events[i]) expected_events.push_back(item_events[i]);
    endfunction

    function automatic bit field_ok(input string field, input int unsigned want,
                                    input int unsigned seen);
        if (want == seen) return 1'b1;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, seen);
        return 1'b0;
    endfunction

    // Transfers on all three channels, sampled at the rising edge
    always @(posedge i_clk) begin
        t_key_event want;
        bit         ok;
        if (!i_rst_n) begin
            enter_delay   = jkef_pkg::ENTER_DELAY_RST;
            release_delay = jkef_pkg::RELEASE_DELAY_RST;
            prev_joy      = '0;
            prev_keys     = '0;
            active_key    = jkef_pkg::KEY_ID_NONE;
            queued_key    = jkef_pkg::KEY_ID_NONE;
            timer_running = 1'b0;
            timer_left    = '0;
            idle_ticks    = '0;
            expected_events.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    jkef_pkg::CFG_ENTER_DELAY:   enter_delay = i_cfg.data;
                    jkef_pkg::CFG_RELEASE_DELAY: release_delay = i_cfg.data;
                    default: ;
                endcase
            end
            if (i_evt.valid && i_evt.ready) begin
                if (expected_events.size() == 0) begin
                    $display("%0t: key event mismatch: expected none, actual code %0d pressed %0d last %0d",
                             $time, i_evt.key_code, i_evt.pressed, i_evt.last_event);
                    fail_total++;
                end else begin
                    want = expected_events.pop_front();
                    ok = field_ok("key_code", want.key_code, i_evt.key_code);
                    ok = field_ok("pressed", want.pressed, i_evt.pressed) && ok;
                    ok = field_ok("last_event", want.last_event, i_evt.last_event) && ok;
                    if (!ok) fail_total++;
                end
            end
            if (i_in.valid && i_in.ready)
                predict_item(i_in.req_type, i_in.joystick_port, i_in.key_port);
        end
        o_pending <= expected_events.size();
    end

    initial begin
        fail_total = 0;
    end

endmodule

>>> dv/joystick_key_event_filter_test.sv
// Top of the joystick key event filter test: clock, reset, item and register
// stimulus with random sender bursts and receiver stalls, and the verdict.
// Depends on jkef_pkg, jkef_if.sv, jkef_event_checker and the block itself.
module joystick_key_event_filter_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HOLD_CYCLES  = 150;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned TIMEOUT_NS   = 3_000_000;

    localparam int unsigned PW = jkef_pkg::PORT_W;

    localparam logic [PW-1:0] JOY_BUTTON  = PW'(1 << jkef_pkg::JOY_BIT_BUTTON);
    localparam logic [PW-1:0] JOY_UP      = PW'(1 << jkef_pkg::JOY_BIT_UP);
    localparam logic [PW-1:0] JOY_LEFT    = PW'(1 << jkef_pkg::JOY_BIT_LEFT);
    localparam logic [PW-1:0] JOY_RIGHT   = PW'(1 << jkef_pkg::JOY_BIT_RIGHT);
    localparam logic [PW-1:0] JOY_UNUSED  = ~PW'((1 << (jkef_pkg::JOY_BIT_RIGHT + 1)) - 1);
    localparam logic [PW-1:0] SIDE_ALL    = PW'((1 << jkef_pkg::SIDE_KEY_CNT) - 1);
    localparam logic [PW-1:0] KEYS_UNUSED = ~SIDE_ALL;

    // Register indexes that the block has no register for
    localparam logic [jkef_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [jkef_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef enum {RX_STEADY, RX_COIN, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              hold_req = 1'b0;
    logic              hold_done = 1'b0;
    int unsigned       pending_events;
    int unsigned       fail_count;
    logic [PW-1:0]     cur_joy;
    logic [PW-1:0]     cur_keys;
    int unsigned       burst_left;
    bit                gaps_on;

    jkef_in_if  in_ch ();
    jkef_cfg_if cfg_ch ();
    jkef_evt_if evt_ch ();

    joystick_key_event_filter i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_evt   (evt_ch)
    );

    jkef_event_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_cfg        (cfg_ch),
        .i_evt        (evt_ch),
        .o_pending    (pending_events),
        .o_fail_count (fail_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // One item transfer; bursts of random length, random gaps between them
    task automatic send_item(input logic kind, input logic [PW-1:0] joy,
                             input logic [PW-1:0] keys);
        int unsigned gap;
        in_ch.valid         <= 1'b1;
        in_ch.req_type      <= kind;
        in_ch.joystick_port <= joy;
        in_ch.key_port      <= keys;
        do @(posedge i_clk); while (!in_ch.ready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 10) : $urandom_range(8, 1);
            gap = gaps_on ? $urandom_range(6) : 0;
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Port fields ride along on ticks but are ignored there
    task automatic send_tick();
        send_item(jkef_pkg::REQ_TICK, PW'($urandom), PW'($urandom));
    endtask

    task automatic send_snapshot(input logic [PW-1:0] joy, input logic [PW-1:0] keys);
        cur_joy = joy;
        cur_keys = keys;
        send_item(jkef_pkg::REQ_SNAPSHOT, joy, keys);
    endtask

    // Leaves the register channel valid; the caller drops it after the last write
    task automatic write_reg(input logic [jkef_pkg::CFG_IDX_W-1:0] idx,
                             input logic [jkef_pkg::TICK_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    // Stop sending, wait for every expected event, then let the pipe drain
    task automatic settle();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_events != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Mostly single-line toggles so keys get pressed, held and released
    task automatic run_random(input int unsigned count, input int unsigned tick_pct);
        int unsigned pick;
        int unsigned bit_pos;
        logic [PW-1:0] joy;
        logic [PW-1:0] keys;
        repeat (count) begin
            pick = $urandom_range(99);
            joy = cur_joy;
            keys = cur_keys;
            if (pick < tick_pct) begin
                send_tick();
            end else if (pick < tick_pct + 8) begin
                send_snapshot(PW'($urandom), PW'($urandom));
            end else begin
                pick = $urandom_range(9);
                if (pick < 6) begin
                    bit_pos = $urandom_range(jkef_pkg::JOY_BIT_RIGHT);
                    joy[bit_pos] = ~joy[bit_pos];
                end else if (pick < 9) begin
                    bit_pos = $urandom_range(jkef_pkg::SIDE_KEY_CNT - 1);
                    keys[bit_pos] = ~keys[bit_pos];
                end else if ($urandom_range(1) == 0) begin
                    bit_pos = $urandom_range(PW - 1, jkef_pkg::JOY_BIT_RIGHT + 1);
                    joy[bit_pos] = ~joy[bit_pos];
                end else begin
                    bit_pos = $urandom_range(PW - 1, jkef_pkg::SIDE_KEY_CNT);
                    keys[bit_pos] = ~keys[bit_pos];
                end
                send_snapshot(joy, keys);
            end
        end
    endtask

    // Event receiver: a new random stall pattern for each span of random length
    initial begin : receiver
        t_rx_mode    mode;
        int unsigned span;
        int unsigned cycle_cnt;
        evt_ch.ready <= 1'b0;
        cycle_cnt = 0;
        forever begin
            mode = t_rx_mode'($urandom_range(3));
            span = $urandom_range(60, 5);
            repeat (span) begin
                @(posedge i_clk);
                cycle_cnt++;
                // long hold-off so the block fills up and stalls its input
                if (hold_req && !hold_done) begin
                    evt_ch.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                    hold_done <= 1'b1;
                end
                case (mode)
                    RX_STEADY:   evt_ch.ready <= 1'b1;
                    RX_COIN:     evt_ch.ready <= $urandom_range(1);
                    RX_SPARSE:   evt_ch.ready <= ($urandom_range(3) == 0);
                    RX_PERIODIC: evt_ch.ready <= (cycle_cnt % 3 == 0);
                    default:     evt_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    initial begin : stimulus
        i_rst_n             <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.req_type      <= jkef_pkg::REQ_SNAPSHOT;
        in_ch.joystick_port <= '0;
        in_ch.key_port      <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= jkef_pkg::CFG_ENTER_DELAY;
        cfg_ch.data         <= '0;
        cur_joy = '0;
        cur_keys = '0;
        burst_left = 0;
        gaps_on = 1'b1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values: button too soon, then an up release held the full delay
        send_snapshot(JOY_BUTTON, '0);
        send_snapshot(JOY_UP, '0);
        send_snapshot('0, '0);
        repeat (jkef_pkg::RELEASE_DELAY_RST) send_tick();
        settle();

        write_reg(jkef_pkg::CFG_ENTER_DELAY, 16'd3);
        write_reg(jkef_pkg::CFG_RELEASE_DELAY, 16'd2);
        cfg_ch.valid <= 1'b0;

        // Directed: enter timing, held and cancelled releases, all side keys
        send_snapshot(JOY_BUTTON, '0);              // too soon: dropped
        repeat (4) send_tick();
        send_snapshot('0, '0);                      // release with nothing active
        send_snapshot(JOY_BUTTON, '0);              // enter press
        send_snapshot('0, '0);                      // release held, timer starts
        send_snapshot(JOY_BUTTON, '0);              // bounce cancels it
        send_snapshot('0, '0);                      // held again on the running timer
        repeat (2) send_tick();                     // enter release
        send_snapshot(JOY_UP, '0);
        send_snapshot(JOY_UP | JOY_RIGHT, '0);      // second key while up active
        send_snapshot(JOY_RIGHT, '0);
        send_snapshot(JOY_UP | JOY_RIGHT, '0);      // cancelled, timer keeps going
        repeat (2) send_tick();                     // expires with nothing held
        send_snapshot('1, '1);
        send_snapshot('0, '0);
        repeat (2) send_tick();
        send_snapshot(JOY_LEFT, SIDE_ALL);          // joystick press plus four side keys
        send_snapshot(JOY_LEFT, KEYS_UNUSED);
        send_snapshot(JOY_LEFT | JOY_UNUSED, KEYS_UNUSED);
        settle();

        // Both delays set to one
        write_reg(jkef_pkg::CFG_ENTER_DELAY, 16'd1);
        write_reg(jkef_pkg::CFG_RELEASE_DELAY, 16'd1);
        cfg_ch.valid <= 1'b0;
        run_random(80, 35);
        settle();

        // Random small delays
        repeat (2) begin
            write_reg(jkef_pkg::CFG_ENTER_DELAY, jkef_pkg::TICK_W'($urandom_range(8, 1)));
            write_reg(jkef_pkg::CFG_RELEASE_DELAY, jkef_pkg::TICK_W'($urandom_range(6, 1)));
            cfg_ch.valid <= 1'b0;
            run_random(55, 35);
            settle();
        end

        // Button locked out, zero release delay, writes to unused indexes
        write_reg(jkef_pkg::CFG_ENTER_DELAY, jkef_pkg::TICK_MAX);
        write_reg(jkef_pkg::CFG_RELEASE_DELAY, '0);
        write_reg(CFG_SPARE_LO, jkef_pkg::TICK_W'($urandom));
        write_reg(CFG_SPARE_HI, jkef_pkg::TICK_W'($urandom));
        cfg_ch.valid <= 1'b0;
        run_random(50, 40);
        settle();

        // Largest delays
        write_reg(jkef_pkg::CFG_ENTER_DELAY, jkef_pkg::TICK_MAX - 1'b1);
        write_reg(jkef_pkg::CFG_RELEASE_DELAY, jkef_pkg::TICK_MAX);
        cfg_ch.valid <= 1'b0;
        run_random(40, 30);
        settle();

        // Back-pressure: receiver holds off while side keys keep toggling
        gaps_on = 1'b0;
        hold_req <= 1'b1;
        repeat (40) send_snapshot(cur_joy, cur_keys ^ SIDE_ALL);
        settle();

        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

endmodule

>>> joystick_key_event_filter.f
hdl/jkef_pkg.sv
hdl/jkef_if.sv
hdl/jkef_front.sv
hdl/jkef_queue.sv
hdl/jkef_back.sv
hdl/joystick_key_event_filter.sv
dv/jkef_event_checker.sv
dv/joystick_key_event_filter_test.sv
